>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
// same-cycle implication checked outside reset
`define ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_IMPL(label, cond, expr)
`endif
`endif

>>> rtl/mtsg_pkg.sv
// types, constants and tables of the multitone sine generator
package mtsg_pkg;

    localparam int TONES_MAX      = 3;
    localparam int TONE_W         = 2;
    localparam int CORDIC_MAX     = 24;
    localparam int ITER_W         = 5;
    localparam int CW             = 34;
    localparam int PM_W           = 34;
    localparam int QM_W           = 61;
    localparam int W_W            = 36;
    localparam int DEF_TONE_COUNT = 3;
    localparam int DEF_SINE_BITS  = 16;

    localparam logic [31:0]   TWO_PI_Q29      = 32'd3373259426;
    localparam logic [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);
    localparam logic [QM_W-1:0] TERM_LIM      = QM_W'(1) << 60;

    // arctangent of 2^-i in quarter turns over 2^30
    localparam logic [31:0] ARC_TABLE [CORDIC_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // configuration register indexes
    localparam logic [2:0] CFG_DC    = 3'd0;
    localparam logic [2:0] CFG_AMP0  = 3'd1;
    localparam logic [2:0] CFG_AMP1  = 3'd2;
    localparam logic [2:0] CFG_AMP2  = 3'd3;
    localparam logic [2:0] CFG_STEP0 = 3'd4;
    localparam logic [2:0] CFG_STEP1 = 3'd5;
    localparam logic [2:0] CFG_STEP2 = 3'd6;
    localparam logic [2:0] CFG_TICK  = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE, S_PHASE, S_MGO, S_MWAIT, S_MPOST, S_CGO, S_CWAIT, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_WT, OP_WK, OP_PS, OP_PC, OP_VEL, OP_AC1, OP_AC2
    } t_op;

endpackage

>>> rtl/mtsg_mul.sv
// shared multiplier: 64x64 product from four 32x32 partial products
`include "assert_macros.svh"
module mtsg_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    import mtsg_pkg::*;

    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_pp;
    logic [1:0]   r_pk;
    logic [127:0] r_acc;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [1:0]   pp_sh;
    logic [127:0] pp_ext;

    // operand halves for the current partial product
    assign a_half = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_half = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign pp_sh  = {1'b0, r_pk[1]} + {1'b0, r_pk[0]};
    assign pp_ext = {64'b0, r_pp} << {pp_sh, 5'b0};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial products and accumulation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != 3'd4) begin
                r_pp <= a_half * b_half;
                r_pk <= r_cnt[1:0];
            end
            if (r_cnt != 3'd0) begin
                r_acc <= r_acc + pp_ext;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    `ASSERT_IMPL(a_mul_done_after_busy, r_done, $past(r_busy) && !r_busy)
    `ASSERT_IMPL(a_mul_no_restart, i_start, !r_busy)
endmodule

>>> rtl/mtsg_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
`include "assert_macros.svh"
module mtsg_cordic #(
    parameter int SINE_BITS = mtsg_pkg::DEF_SINE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [31:0]                 i_phase,
    output logic                        o_done,
    output logic signed [SINE_BITS+1:0] o_sin,
    output logic signed [SINE_BITS+1:0] o_cos
);
    import mtsg_pkg::*;

    localparam int SHIFT = 30 - SINE_BITS;
    localparam logic signed [CW-1:0] HALF = CW'(1) << (SHIFT - 1);
    localparam logic [1:0] Q_FIRST  = 2'd0;
    localparam logic [1:0] Q_SECOND = 2'd1;
    localparam logic [1:0] Q_THIRD  = 2'd2;

    logic                        r_busy;
    logic                        r_fin;
    logic                        r_done;
    logic [ITER_W-1:0]           r_i;
    logic [1:0]                  r_quad;
    logic signed [CW-1:0]        r_x;
    logic signed [CW-1:0]        r_y;
    logic signed [CW-1:0]        r_z;
    logic signed [SINE_BITS+1:0] r_sin;
    logic signed [SINE_BITS+1:0] r_cos;
    logic signed [CW-1:0]        xs;
    logic signed [CW-1:0]        ys;
    logic signed [CW-1:0]        arc;
    logic signed [CW-1:0]        yr;
    logic signed [CW-1:0]        xr;
    logic signed [SINE_BITS+1:0] si;
    logic signed [SINE_BITS+1:0] co;

    // shifted terms and rounded outputs
    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign arc = $signed({{(CW-32){1'b0}}, ARC_TABLE[r_i]});
    assign yr  = (r_y + HALF) >>> SHIFT;
    assign xr  = (r_x + HALF) >>> SHIFT;
    assign si  = yr[SINE_BITS+1:0];
    assign co  = xr[SINE_BITS+1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == ITER_W'(SINE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // rotation datapath and quadrant fold
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= $signed(CORDIC_GAIN_Q30);
            r_y    <= '0;
            r_z    <= $signed({{(CW-30){1'b0}}, i_phase[29:0]});
            r_quad <= i_phase[31:30];
        end else if (r_busy) begin
            if (!r_z[CW-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - arc;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + arc;
            end
        end else if (r_fin) begin
            case (r_quad)
                Q_FIRST: begin
                    r_sin <= si;
                    r_cos <= co;
                end
                Q_SECOND: begin
                    r_sin <= co;
                    r_cos <= -si;
                end
                Q_THIRD: begin
                    r_sin <= -si;
                    r_cos <= -co;
                end
                default: begin
                    r_sin <= -co;
                    r_cos <= si;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

    `ASSERT_IMPL(a_cor_no_restart, i_start, !r_busy && !r_fin)
endmodule

>>> rtl/multitone_sine_generator.sv
// three-tone sine generator: position, velocity, acceleration per tick
// ticks are taken one at a time: a new tick is accepted only in the idle state, after the last
// result has been loaded into the output register; the shared 32x32 multiplier
// (7 products per tone, 4 partials each) and the one-rotation-per-cycle cordic do the work
// reset: synchronous active low; phases and configuration registers cleared, tick rate 1000
// a finished result waits in the output register while the next tick is taken
`include "assert_macros.svh"
module multitone_sine_generator #(
    parameter int TONE_COUNT = mtsg_pkg::DEF_TONE_COUNT,
    parameter int SINE_BITS  = mtsg_pkg::DEF_SINE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_position,
    output logic [31:0] o_velocity,
    output logic [31:0] o_acceleration,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import mtsg_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [31:0]            r_dc;
    logic [31:0]            r_amp  [TONES_MAX];
    logic [31:0]            r_step [TONES_MAX];
    logic [15:0]            r_tick;
    logic [31:0]            r_phase [TONES_MAX];
    logic [TONE_W-1:0]      r_tone;
    logic                   r_restart;
    logic [47:0]            r_wt;
    logic [W_W-1:0]         r_w;
    logic [PM_W-1:0]        r_psm;
    logic                   r_pss;
    logic [PM_W-1:0]        r_pcm;
    logic                   r_pcs;
    logic [QM_W-1:0]        r_m;
    logic signed [63:0]     r_pos;
    logic signed [63:0]     r_vel;
    logic signed [63:0]     r_acc;
    logic                   r_out_valid;
    logic [31:0]            r_out_pos;
    logic [31:0]            r_out_vel;
    logic [31:0]            r_out_acc;

    logic                        mul_start;
    logic [63:0]                 mul_a;
    logic [63:0]                 mul_b;
    logic                        mul_done;
    logic [127:0]                mul_prod;
    logic                        cor_start;
    logic                        cor_done;
    logic signed [SINE_BITS+1:0] cor_sin;
    logic signed [SINE_BITS+1:0] cor_cos;

    logic [31:0]          amp_cur;
    logic [32:0]          amp_mag;
    logic [SINE_BITS+1:0] sin_mag;
    logic [SINE_BITS+1:0] cos_mag;
    logic [127:0]         w_full;
    logic [127:0]         pm_full;
    logic [127:0]         q_full;
    logic [PM_W-1:0]      pm;
    logic [111:0]         q_raw;
    logic [QM_W-1:0]      q_lim;
    logic                 accept_in;
    logic                 last_tone;
    logic                 out_load;

    // units
    mtsg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mtsg_cordic #(.SINE_BITS(SINE_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_phase (r_phase[r_tone]),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    // magnitudes of signed operands
    assign amp_cur = r_amp[r_tone];
    assign amp_mag = amp_cur[31] ? (33'd0 - {1'b1, amp_cur}) : {1'b0, amp_cur};
    assign sin_mag = cor_sin[SINE_BITS+1] ? $unsigned(-cor_sin) : $unsigned(cor_sin);
    assign cos_mag = cor_cos[SINE_BITS+1] ? $unsigned(-cor_cos) : $unsigned(cor_cos);

    // rounding of the shared product
    assign w_full  = mul_prod + (128'd1 << 44);
    assign pm_full = (mul_prod + (128'd1 << (SINE_BITS - 1))) >> SINE_BITS;
    assign pm      = pm_full[PM_W-1:0];
    assign q_full  = mul_prod + 128'h8000;
    assign q_raw   = q_full[127:16];
    assign q_lim   = (q_raw > {{(112-QM_W){1'b0}}, TERM_LIM}) ? TERM_LIM : q_raw[QM_W-1:0];

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            OP_WT: begin
                mul_a = {32'b0, r_step[r_tone]};
                mul_b = {48'b0, r_tick};
            end
            OP_WK: begin
                mul_a = {16'b0, r_wt};
                mul_b = {32'b0, TWO_PI_Q29};
            end
            OP_PS: begin
                mul_a = {31'b0, amp_mag};
                mul_b = 64'(sin_mag);
            end
            OP_PC: begin
                mul_a = {31'b0, amp_mag};
                mul_b = 64'(cos_mag);
            end
            OP_VEL: begin
                mul_a = 64'(r_pcm);
                mul_b = 64'(r_w);
            end
            OP_AC1: begin
                mul_a = 64'(r_psm);
                mul_b = 64'(r_w);
            end
            OP_AC2: begin
                mul_a = 64'(r_w);
                mul_b = 64'(r_m);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign accept_in = i_valid && (r_state == S_IDLE);
    assign last_tone = (r_tone == TONE_W'(TONE_COUNT - 1));
    assign out_load  = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        mul_start = 1'b0;
        cor_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE: begin
                n_op    = OP_WT;
                n_state = S_MGO;
            end
            S_MGO: begin
                mul_start = 1'b1;
                n_state   = S_MWAIT;
            end
            S_MWAIT: begin
                if (mul_done) begin
                    n_state = S_MPOST;
                end
            end
            S_MPOST: begin
                case (r_op)
                    OP_WT: begin
                        n_op    = OP_WK;
                        n_state = S_MGO;
                    end
                    OP_WK: begin
                        n_state = S_CGO;
                    end
                    OP_PS: begin
                        n_op    = OP_PC;
                        n_state = S_MGO;
                    end
                    OP_PC: begin
                        n_op    = OP_VEL;
                        n_state = S_MGO;
                    end
                    OP_VEL: begin
                        n_op    = OP_AC1;
                        n_state = S_MGO;
                    end
                    OP_AC1: begin
                        n_op    = OP_AC2;
                        n_state = S_MGO;
                    end
                    default: begin
                        n_state = last_tone ? S_FIN : S_PHASE;
                    end
                endcase
            end
            S_CGO: begin
                cor_start = 1'b1;
                n_state   = S_CWAIT;
            end
            S_CWAIT: begin
                if (cor_done) begin
                    n_op    = OP_PS;
                    n_state = S_MGO;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_WT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // configuration registers and tone phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc   <= '0;
            r_tick <= 16'd1000;
            for (int t = 0; t < TONES_MAX; t++) begin
                r_amp[t]   <= '0;
                r_step[t]  <= '0;
                r_phase[t] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DC:    r_dc      <= i_cfg_data;
                    CFG_AMP0:  r_amp[0]  <= i_cfg_data;
                    CFG_AMP1:  r_amp[1]  <= i_cfg_data;
                    CFG_AMP2:  r_amp[2]  <= i_cfg_data;
                    CFG_STEP0: r_step[0] <= i_cfg_data;
                    CFG_STEP1: r_step[1] <= i_cfg_data;
                    CFG_STEP2: r_step[2] <= i_cfg_data;
                    CFG_TICK:  r_tick    <= i_cfg_data[15:0];
                    default:   r_tick    <= r_tick;
                endcase
            end
            if (r_state == S_PHASE) begin
                r_phase[r_tone] <= r_restart ? 32'd0 : r_phase[r_tone] + r_step[r_tone];
            end
        end
    end

    // tone counter and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone <= '0;
        end else if (accept_in) begin
            r_tone <= '0;
        end else if (r_state == S_MPOST && r_op == OP_AC2 && !last_tone) begin
            r_tone <= r_tone + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_restart <= i_restart;
            r_pos     <= {{32{r_dc[31]}}, r_dc};
            r_vel     <= '0;
            r_acc     <= '0;
        end else if (r_state == S_MPOST) begin
            case (r_op)
                OP_WT:  r_wt <= mul_prod[47:0];
                OP_WK:  r_w  <= w_full[45+W_W-1:45];
                OP_PS: begin
                    r_psm <= pm;
                    r_pss <= amp_cur[31] ^ cor_sin[SINE_BITS+1];
                    if (amp_cur[31] ^ cor_sin[SINE_BITS+1]) begin
                        r_pos <= r_pos - $signed(64'(pm));
                    end else begin
                        r_pos <= r_pos + $signed(64'(pm));
                    end
                end
                OP_PC: begin
                    r_pcm <= pm;
                    r_pcs <= amp_cur[31] ^ cor_cos[SINE_BITS+1];
                end
                OP_VEL: begin
                    if (r_pcs) begin
                        r_vel <= r_vel - $signed(64'(q_lim));
                    end else begin
                        r_vel <= r_vel + $signed(64'(q_lim));
                    end
                end
                OP_AC1: r_m <= q_lim;
                default: begin
                    if (r_pss) begin
                        r_acc <= r_acc + $signed(64'(q_lim));
                    end else begin
                        r_acc <= r_acc - $signed(64'(q_lim));
                    end
                end
            endcase
        end
    end

    // output register with saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos <= sat32(r_pos);
            r_out_vel <= sat32(r_vel);
            r_out_acc <= sat32(r_acc);
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_velocity     = r_out_vel;
    assign o_acceleration = r_out_acc;

    `ASSERT_IMPL(a_mul_done_in_wait, mul_done, r_state == S_MWAIT)
    `ASSERT_IMPL(a_cor_done_in_wait, cor_done, r_state == S_CWAIT)
    `ASSERT_CLK(a_tone_in_range, r_tone <= TONE_W'(TONE_COUNT - 1))
endmodule

>>> test/multitone_sine_generator_tb.sv
// testbench of the multitone sine generator: predicted position, velocity, acceleration
module multitone_sine_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtsg_pkg::*;

    localparam int NTONE = DEF_TONE_COUNT;
    localparam int SBITS = DEF_SINE_BITS;
    localparam int DRAIN = 400;
    localparam longint LIMIT = 4000000;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
    } t_motion;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_restart = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_position, o_velocity, o_acceleration;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = CFG_DC;
    logic [31:0] i_cfg_data = 0;

    multitone_sine_generator u_dut (.*);

    // predictor state and registers
    logic [31:0] mdl_dc;
    logic [31:0] mdl_amp [3];
    logic [31:0] mdl_step [3];
    logic [15:0] mdl_tick;
    logic [31:0] mdl_phase [3];

    bit          pending_ticks [$];
    t_motion     expected_motion [$];
    int          errors = 0;
    int          send_idle = 0, recv_stall = 0;
    longint      cycles = 0;
    bit          in_taken = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // unsigned q16 product limited to 2^60
    function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
        longint unsigned bh, bl, r, lim;
        lim = 64'd1 << 60;
        bh = b >> 16;
        bl = b & 64'hFFFF;
        if (bh != 0 && a > lim / bh) return lim;
        r = a * bh + ((a * bl + 64'h8000) >> 16);
        return r > lim ? lim : r;
    endfunction

    function automatic longint amp_times(longint amp, longint t);
        longint unsigned ma, mt, m;
        ma = amp < 0 ? -amp : amp;
        mt = t < 0 ? -t : t;
        m = (ma * mt + (64'd1 << (SBITS - 1))) >> SBITS;
        return ((amp < 0) != (t < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned omega(logic [31:0] st);
        longint unsigned w, a, b, ah, al;
        w = longint'(st) * longint'(mdl_tick);
        a = (w >> 24) * longint'(TWO_PI_Q29);
        b = (w & 64'hFFFFFF) * longint'(TWO_PI_Q29);
        ah = a >> 21;
        al = a & 64'h1FFFFF;
        return ah + (((al << 24) + b + (64'd1 << 44)) >> 45);
    endfunction

    task automatic cordic(input logic [31:0] ph, output longint s, output longint c);
        longint x, y, z, nx, si, co, half;
        int sh;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        z = ph[29:0];
        sh = 30 - SBITS;
        half = 64'sd1 <<< (sh - 1);
        for (int i = 0; i < SBITS && i < CORDIC_MAX; i++) begin
            if (z >= 0) begin
                nx = x - fshift(y, i);
                y = y + fshift(x, i);
                z -= longint'(ARC_TABLE[i]);
            end else begin
                nx = x + fshift(y, i);
                y = y - fshift(x, i);
                z += longint'(ARC_TABLE[i]);
            end
            x = nx;
        end
        si = fshift(y + half, sh);
        co = fshift(x + half, sh);
        case (ph[31:30])
            2'd0: begin s = si; c = co; end
            2'd1: begin s = co; c = -si; end
            2'd2: begin s = -si; c = -co; end
            default: begin s = -co; c = si; end
        endcase
    endtask

    // advance phases and compute the motion triple for one tick
    task automatic predict_motion(input bit rs);
        longint pos, vel, acc, amp, s, c, ps, pc;
        longint unsigned w, m;
        t_motion r;
        pos = longint'(signed'(mdl_dc));
        vel = 0;
        acc = 0;
        for (int t = 0; t < NTONE; t++) begin
            mdl_phase[t] = rs ? 32'd0 : mdl_phase[t] + mdl_step[t];
            amp = longint'(signed'(mdl_amp[t]));
            w = omega(mdl_step[t]);
            cordic(mdl_phase[t], s, c);
            ps = amp_times(amp, s);
            pc = amp_times(amp, c);
            pos += ps;
            m = q16_mul(pc < 0 ? -pc : pc, w);
            vel += pc < 0 ? -longint'(m) : longint'(m);
            m = q16_mul(ps < 0 ? -ps : ps, w);
            m = q16_mul(w, m);
            acc += ps < 0 ? longint'(m) : -longint'(m);
        end
        r.pos = 32'(sat32(pos));
        r.vel = 32'(sat32(vel));
        r.acc = 32'(sat32(acc));
        expected_motion.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // driver: one transaction per queued tick, random idling
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && !in_taken)) begin
        end else if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle) begin
            i_valid <= 1;
            i_restart <= pending_ticks.pop_front();
        end else begin
            i_valid <= 0;
            i_restart <= $urandom_range(1);
        end
        i_stall <= $urandom_range(99) < recv_stall;
    end

    // monitor: record input transactions, compare results with the oldest prediction
    always @(posedge i_clk) begin
        t_motion e;
        cycles++;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            predict_motion(i_restart);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_motion.size() == 0) begin
                report("result with nothing expected", o_position, 32'h0);
            end else begin
                e = expected_motion.pop_front();
                if (o_position !== e.pos) report("position", o_position, e.pos);
                if (o_velocity !== e.vel) report("velocity", o_velocity, e.vel);
                if (o_acceleration !== e.acc) report("acceleration", o_acceleration, e.acc);
            end
        end
        if (cycles > LIMIT) begin
            $display("multitone_sine_generator_tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_DC: mdl_dc = val;
            CFG_AMP0, CFG_AMP1, CFG_AMP2: mdl_amp[idx - CFG_AMP0] = val;
            CFG_STEP0, CFG_STEP1, CFG_STEP2: mdl_step[idx - CFG_STEP0] = val;
            default: mdl_tick = val[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || i_valid || expected_motion.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(131072)) - 65536);
            4: return $urandom & 32'h00FFFFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config(input int mode);
        write_reg(CFG_DC, pick_word());
        for (int t = 0; t < 3; t++) begin
            write_reg(3'(CFG_AMP0 + t), mode == 1 ? 32'h7FFFFFFF : pick_word());
            write_reg(3'(CFG_STEP0 + t), mode == 1 ? 32'hFFFFFFFF :
                      ($urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 26)));
        end
        write_reg(CFG_TICK, mode == 1 ? 32'hFFFF : mode == 2 ? 32'h0 :
                  32'($urandom_range(65535, 1)));
    endtask

    initial begin
        mdl_dc = 0;
        mdl_tick = 1000;
        for (int t = 0; t < 3; t++) begin
            mdl_amp[t] = 0;
            mdl_step[t] = 0;
            mdl_phase[t] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: reset values, then extremes, tick rate zero, restarts
        pending_ticks = '{0, 1, 0};
        drain();
        write_reg(CFG_DC, 32'h7FFFFFFF);
        write_reg(CFG_AMP0, 32'h00010000);
        write_reg(CFG_AMP1, 32'h80000000);
        write_reg(CFG_AMP2, 32'h7FFFFFFF);
        write_reg(CFG_STEP0, 32'h40000000);
        write_reg(CFG_STEP1, 32'h10000000);
        write_reg(CFG_STEP2, 32'hFFFFFFFF);
        write_reg(CFG_TICK, 32'h0000FFFF);
        pending_ticks = '{1, 0, 0, 0, 0, 1, 0};
        drain();
        write_reg(CFG_DC, 32'h80000000);
        write_reg(CFG_TICK, 32'h0);
        pending_ticks = '{0, 0, 1, 0, 0};
        drain();
        write_reg(CFG_TICK, 32'h1);
        pending_ticks = '{0, 0, 0, 1, 0};
        drain();
        // random phases with the four idling patterns
        for (int ph = 0; ph < 16; ph++) begin
            random_config(ph % 6 == 1 ? 1 : ph % 6 == 2 ? 2 : 0);
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 80; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 80; end
                default: begin send_idle = 33; recv_stall = 33; end
            endcase
            for (int k = 0; k < 85; k++)
                pending_ticks.push_back($urandom_range(15) == 0);
            drain();
        end
        if (errors == 0)
            $display("multitone_sine_generator_tb OK");
        else
            $display("multitone_sine_generator_tb NOT OK");
        $finish;
    end
endmodule
